### sv/tmgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map renderer package
// Shared widths, codes and item types of the tile map ground renderer.
// ----------------------------------------------------------------------------
package tmgr_pkg;

    localparam int GRID_CELLS_DEF = 4096;
    localparam int PALETTE_SIZE   = 8;

    localparam int OP_W       = 2;
    localparam int COORD_W    = 10;
    localparam int CELL_IDX_W = 12;
    localparam int SURF_W     = 3;
    localparam int SLOT_W     = 3;
    localparam int COLOR_W    = 16;
    localparam int POS_W      = 16;
    localparam int CS_W       = 8;
    localparam int DIM_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Pixel offset from the grid origin spans -65535 .. 66558.
    localparam int OFS_W   = 18;
    localparam int MAG_W   = 17;
    // Only quotients below 128 can land inside a 7-bit grid dimension.
    localparam int Q_W     = 7;
    localparam int DIV_LAT = Q_W + 1;
    // Wide enough for a row-major cell index and for the largest grid size.
    localparam int IDX_W   = 17;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [SURF_W-1:0] GRASS_SURFACE = 3'd3;
    localparam logic [CS_W-1:0]   CS_RESET      = 8'd16;
    localparam logic [DIM_W-1:0]  DIM_RESET     = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_RENDER  = 2'd0,
        OP_GRID_WR = 2'd1,
        OP_PAL_WR  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_RENDER  = 2'd0,
        KIND_GRID_WR = 2'd1,
        KIND_PAL_WR  = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VIEW_LEFT     = 3'd0,
        REG_VIEW_TOP      = 3'd1,
        REG_GRID_ORIGIN_X = 3'd2,
        REG_GRID_ORIGIN_Y = 3'd3,
        REG_CELL_SIZE     = 3'd4,
        REG_GRID_WIDTH    = 3'd5,
        REG_GRID_HEIGHT   = 3'd6
    } t_reg;

    typedef struct packed {
        logic signed [POS_W-1:0] view_left;
        logic signed [POS_W-1:0] view_top;
        logic signed [POS_W-1:0] grid_origin_x;
        logic signed [POS_W-1:0] grid_origin_y;
        logic [CS_W-1:0]         cell_size;
        logic [DIM_W-1:0]        grid_width;
        logic [DIM_W-1:0]        grid_height;
    } t_cfg;

    typedef struct packed {
        t_kind                   kind;
        logic [OFS_W-1:0]        dx;
        logic [OFS_W-1:0]        dy;
        logic [CELL_IDX_W-1:0]   cell_index;
        logic [SURF_W-1:0]       surface_code;
        logic [SLOT_W-1:0]       palette_slot;
        logic [COLOR_W-1:0]      slot_color;
    } t_task;

endpackage

### sv/tmgr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map renderer channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tmgr_req_if;
    import tmgr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       op;
    logic [COORD_W-1:0]    screen_x;
    logic [COORD_W-1:0]    screen_y;
    logic [CELL_IDX_W-1:0] cell_index;
    logic [SURF_W-1:0]     surface_code;
    logic [SLOT_W-1:0]     palette_slot;
    logic [COLOR_W-1:0]    slot_color;

    modport source (
        output valid, op, screen_x, screen_y, cell_index, surface_code,
               palette_slot, slot_color,
        input  ready
    );
    modport sink (
        input  valid, op, screen_x, screen_y, cell_index, surface_code,
               palette_slot, slot_color,
        output ready
    );
endinterface

interface tmgr_res_if;
    import tmgr_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;
    logic [SURF_W-1:0]  pixel_surface;

    modport source (output valid, pixel_color, pixel_surface, input ready);
    modport sink (input valid, pixel_color, pixel_surface, output ready);
endinterface

interface tmgr_cfg_if;
    import tmgr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### sv/tmgr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map renderer front end
// Holds the configuration registers, accepts request items, sorts them by
// operation and computes the pixel offset from the grid origin.
// ----------------------------------------------------------------------------
module tmgr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tmgr_req_if.sink        i_req,
    tmgr_cfg_if.sink        i_cfg,
    input  logic            i_q_full,
    output logic            o_push,
    output tmgr_pkg::t_task o_task,
    output tmgr_pkg::t_cfg  o_cfg
);
    import tmgr_pkg::*;

    t_cfg             r_cfg;
    t_cfg             n_cfg;
    t_kind            w_kind;
    logic             w_known;
    logic [OFS_W-1:0] w_vl;
    logic [OFS_W-1:0] w_vt;
    logic [OFS_W-1:0] w_ox;
    logic [OFS_W-1:0] w_oy;
    logic [OFS_W-1:0] w_sx;
    logic [OFS_W-1:0] w_sy;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !i_q_full;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (t_reg'(i_cfg.index))
                REG_VIEW_LEFT:     n_cfg.view_left     = $signed(i_cfg.data);
                REG_VIEW_TOP:      n_cfg.view_top      = $signed(i_cfg.data);
                REG_GRID_ORIGIN_X: n_cfg.grid_origin_x = $signed(i_cfg.data);
                REG_GRID_ORIGIN_Y: n_cfg.grid_origin_y = $signed(i_cfg.data);
                REG_CELL_SIZE:     n_cfg.cell_size     = i_cfg.data[CS_W-1:0];
                REG_GRID_WIDTH:    n_cfg.grid_width    = i_cfg.data[DIM_W-1:0];
                REG_GRID_HEIGHT:   n_cfg.grid_height   = i_cfg.data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_left     <= '0;
            r_cfg.view_top      <= '0;
            r_cfg.grid_origin_x <= '0;
            r_cfg.grid_origin_y <= '0;
            r_cfg.cell_size     <= CS_RESET;
            r_cfg.grid_width    <= DIM_RESET;
            r_cfg.grid_height   <= DIM_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // The unused operation code is taken and dropped without a result.
    always_comb begin
        w_kind  = KIND_RENDER;
        w_known = 1'b1;
        case (t_op'(i_req.op))
            OP_RENDER:  w_kind = KIND_RENDER;
            OP_GRID_WR: w_kind = KIND_GRID_WR;
            OP_PAL_WR:  w_kind = KIND_PAL_WR;
            default:    w_known = 1'b0;
        endcase
    end

    assign w_vl = {{(OFS_W-POS_W){r_cfg.view_left[POS_W-1]}}, r_cfg.view_left};
    assign w_vt = {{(OFS_W-POS_W){r_cfg.view_top[POS_W-1]}}, r_cfg.view_top};
    assign w_ox = {{(OFS_W-POS_W){r_cfg.grid_origin_x[POS_W-1]}}, r_cfg.grid_origin_x};
    assign w_oy = {{(OFS_W-POS_W){r_cfg.grid_origin_y[POS_W-1]}}, r_cfg.grid_origin_y};
    assign w_sx = {{(OFS_W-COORD_W){1'b0}}, i_req.screen_x};
    assign w_sy = {{(OFS_W-COORD_W){1'b0}}, i_req.screen_y};

    assign o_push = i_req.valid && !i_q_full && w_known;

    always_comb begin
        o_task.kind         = w_kind;
        o_task.dx           = w_vl + w_sx - w_ox;
        o_task.dy           = w_vt + w_sy - w_oy;
        o_task.cell_index   = i_req.cell_index;
        o_task.surface_code = i_req.surface_code;
        o_task.palette_slot = i_req.palette_slot;
        o_task.slot_color   = i_req.slot_color;
    end

endmodule

### sv/tmgr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map renderer item queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module tmgr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tmgr_pkg::t_task i_task,
    output logic            o_full,
    output logic            o_valid,
    output tmgr_pkg::t_task o_task,
    input  logic            i_pop
);
    import tmgr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_task            r_slots [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_task  = r_slots[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### sv/tmgr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map renderer cell divider
// Pipelined restoring divider that turns a signed pixel offset into a grid
// column or row, truncating toward zero, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tmgr_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [tmgr_pkg::OFS_W-1:0] i_dx,
    input  logic [tmgr_pkg::CS_W-1:0]  i_cs,
    output logic [tmgr_pkg::Q_W-1:0]   o_q,
    output logic                       o_ok
);
    import tmgr_pkg::*;

    logic [MAG_W-1:0] r_rem [0:Q_W];
    logic [Q_W-1:0]   r_q   [0:Q_W];
    logic             r_neg [0:Q_W];
    logic             r_bad [0:Q_W];

    logic [OFS_W-1:0] w_abs;
    logic             w_ov;
    logic [MAG_W:0]   w_div  [1:Q_W];
    logic [MAG_W:0]   w_diff [1:Q_W];
    logic             w_take [1:Q_W];
    logic [Q_W-1:0]   w_q    [1:Q_W];

    assign w_abs = i_dx[OFS_W-1] ? (~i_dx + 1'b1) : i_dx;
    // A quotient of 128 or more can never fall inside the grid.
    assign w_ov  = ({1'b0, r_rem[0]} >= ((MAG_W+1)'(i_cs) << Q_W));

    always_comb begin
        for (int j = 1; j <= Q_W; j++) begin
            w_div[j]          = (MAG_W+1)'(i_cs) << (Q_W - j);
            w_diff[j]         = {1'b0, r_rem[j-1]} - w_div[j];
            w_take[j]         = !w_diff[j][MAG_W];
            w_q[j]            = r_q[j-1];
            w_q[j][Q_W - j]   = w_take[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_abs[MAG_W-1:0];
            r_neg[0] <= i_dx[OFS_W-1];
            r_bad[0] <= (i_cs == '0);
            r_q[0]   <= '0;
            r_bad[1] <= r_bad[0] || w_ov;
            for (int j = 1; j <= Q_W; j++) begin
                r_rem[j] <= w_take[j] ? w_diff[j][MAG_W-1:0] : r_rem[j-1];
                r_q[j]   <= w_q[j];
                r_neg[j] <= r_neg[j-1];
                if (j > 1) begin
                    r_bad[j] <= r_bad[j-1];
                end
            end
        end
    end

    // A negative offset inside the first cell still truncates to zero.
    assign o_q  = r_q[Q_W];
    assign o_ok = !r_bad[Q_W] && (!r_neg[Q_W] || (r_q[Q_W] == '0));

endmodule

### sv/tmgr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map renderer back end
// Divides offsets into cells, bounds-checks them, performs grid and palette
// writes and reads in item order, and holds the result register.
// ----------------------------------------------------------------------------
module tmgr_back #(
    parameter int GRID_CELLS = tmgr_pkg::GRID_CELLS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tmgr_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  tmgr_pkg::t_task i_q_task,
    output logic            o_pop,
    tmgr_res_if.source      o_res
);
    import tmgr_pkg::*;

    localparam int AW = $clog2(GRID_CELLS);
    localparam logic [IDX_W-1:0] Cells = IDX_W'(GRID_CELLS);

    logic               w_en;
    logic [Q_W-1:0]     w_qx;
    logic [Q_W-1:0]     w_qy;
    logic               w_okx;
    logic               w_oky;
    logic               w_hit;
    logic [IDX_W-1:0]   w_wr_idx;
    logic               w_grid_we;
    logic [SURF_W-1:0]  w_surf;

    logic               r_sb_valid [0:DIV_LAT-1];
    t_task              r_sb_task  [0:DIV_LAT-1];

    logic               r_a_valid;
    t_task              r_a_task;
    logic [IDX_W-1:0]   r_a_idx;
    logic               r_a_hit;

    logic               r_m_valid;
    t_kind              r_m_kind;
    logic               r_m_inside;
    logic [SURF_W-1:0]  r_m_raw;
    logic [SLOT_W-1:0]  r_m_slot;
    logic [COLOR_W-1:0] r_m_color;

    logic               r_out_valid;
    logic [COLOR_W-1:0] r_out_color;
    logic [SURF_W-1:0]  r_out_surf;

    logic [SURF_W-1:0]  r_grid    [0:GRID_CELLS-1];
    logic [COLOR_W-1:0] r_palette [0:PALETTE_SIZE-1];

    // The whole pipeline advances unless a result is waiting to be taken.
    assign w_en  = !r_out_valid || o_res.ready;
    assign o_pop = w_en && i_q_valid;

    tmgr_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_dx  (i_q_task.dx),
        .i_cs  (i_cfg.cell_size),
        .o_q   (w_qx),
        .o_ok  (w_okx)
    );

    tmgr_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_dx  (i_q_task.dy),
        .i_cs  (i_cfg.cell_size),
        .o_q   (w_qy),
        .o_ok  (w_oky)
    );

    assign w_hit = w_okx && w_oky
                && (w_qx < i_cfg.grid_width) && (w_qy < i_cfg.grid_height);

    assign w_wr_idx  = IDX_W'(r_a_task.cell_index);
    assign w_grid_we = r_a_valid && (r_a_task.kind == KIND_GRID_WR) && (w_wr_idx < Cells);
    assign w_surf    = r_m_inside ? r_m_raw : GRASS_SURFACE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_sb_valid[k] <= 1'b0;
            end
            r_a_valid   <= 1'b0;
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_sb_valid[0] <= i_q_valid;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sb_valid[k] <= r_sb_valid[k-1];
            end
            r_a_valid   <= r_sb_valid[DIV_LAT-1];
            r_m_valid   <= r_a_valid;
            r_out_valid <= r_m_valid && (r_m_kind == KIND_RENDER);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb_task[0] <= i_q_task;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sb_task[k] <= r_sb_task[k-1];
            end
            r_a_task   <= r_sb_task[DIV_LAT-1];
            r_a_idx    <= IDX_W'(w_qy) * IDX_W'(i_cfg.grid_width) + IDX_W'(w_qx);
            r_a_hit    <= w_hit;
            r_m_kind   <= r_a_task.kind;
            r_m_inside <= r_a_hit && (r_a_idx < Cells);
            r_m_slot   <= r_a_task.palette_slot;
            r_m_color  <= r_a_task.slot_color;
            r_out_color <= r_palette[w_surf];
            r_out_surf  <= w_surf;
        end
    end

    // Grid: one write or one registered read per enabled cycle, in item order.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_grid_we) begin
                r_grid[w_wr_idx[AW-1:0]] <= r_a_task.surface_code;
            end
            r_m_raw <= r_grid[r_a_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_m_valid && (r_m_kind == KIND_PAL_WR)) begin
            r_palette[r_m_slot] <= r_m_color;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.pixel_color   = r_out_color;
    assign o_res.pixel_surface = r_out_surf;

endmodule

### sv/tile_map_ground_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map ground renderer
// A taken item passes the divider, address, grid read and result registers.
// Throughput: one item per cycle unless stalled; the divider is pipelined.
// Grid and palette writes pass the same pipeline, so they keep item order.
// Reset clears control state and loads register defaults; the grid and the
// palette are not cleared and hold no defined value until written.
// ----------------------------------------------------------------------------
module tile_map_ground_renderer #(
    parameter int GRID_CELLS = tmgr_pkg::GRID_CELLS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmgr_req_if.sink   i_req,
    tmgr_cfg_if.sink   i_cfg,
    tmgr_res_if.source o_res
);
    import tmgr_pkg::*;

    t_cfg  w_cfg;
    t_task w_push_task;
    t_task w_q_task;
    logic  w_push;
    logic  w_full;
    logic  w_q_valid;
    logic  w_pop;

    tmgr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cfg    (i_cfg),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_task   (w_push_task),
        .o_cfg    (w_cfg)
    );

    tmgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_task  (w_push_task),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_task  (w_q_task),
        .i_pop   (w_pop)
    );

    tmgr_back #(
        .GRID_CELLS (GRID_CELLS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_q_task  (w_q_task),
        .o_pop     (w_pop),
        .o_res     (o_res)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("item pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("item popped from an empty queue");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

endmodule
